// ===== rtl/prpd_pkg.sv =====
`default_nettype none

package prpd_pkg;

    localparam int CODE_W = 8;
    localparam int PIX_W  = 16;
    localparam int DIM_W  = 8;
    localparam int POS_W  = 16;
    localparam int RUN_W  = 4;
    localparam int IDX_W  = 4;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 64;
    localparam int PAL_WORDS = 4;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] REG_PAL0   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_PAL1   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_PAL2   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_PAL3   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_WIDTH  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_HEIGHT = 3'd5;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic run_zero;
        logic last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/prpd_ifs.sv =====
`default_nettype none

interface prpd_code_if;
    logic                        valid;
    logic                        ready;
    logic [prpd_pkg::CODE_W-1:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

interface prpd_pixel_if;
    logic                       valid;
    logic                       ready;
    logic [prpd_pkg::PIX_W-1:0] pixel_word;
    logic                       run_last;
    logic                       frame_last;

    modport source (output valid, output pixel_word, output run_last, output frame_last,
                    input ready);
    modport sink   (input valid, input pixel_word, input run_last, input frame_last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/palette_rle_pixel_decoder_top.sv =====
// Run-length pixel decoder with a 16-entry palette. Each code byte beat
// carries a run length in bits 7:4 and a palette index in bits 3:0; the block
// emits one pixel beat per pixel of the run, with the colour bytes swapped,
// run_last on the final pixel of the run and frame_last on the pixel that
// completes a width x height image (the rest of that run is dropped and the
// position restarts). A code byte with run length zero is consumed and emits
// nothing. An accepted code byte then puts one pixel per cycle into the single
// output register while that register is free, as the receiver can stall it;
// the next code byte is accepted as soon as the last pixel of the run is in
// the output register. Palette and image size are to be written by the user
// through the configuration port while idle only; the block does not enforce
// this. The image size takes effect via r_total, registered from the sizes.
`default_nettype none

module palette_rle_pixel_decoder_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [prpd_pkg::CFG_AW-1:0]  i_cfg_idx,
    input  wire  [prpd_pkg::CFG_DW-1:0]  i_cfg_data,
    prpd_code_if.sink                    i_code,
    prpd_pixel_if.source                 o_pixel
);
    import prpd_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;
    logic  out_valid;
    logic [PIX_W-1:0] pixel_word;
    logic  run_last;
    logic  frame_last;

    prpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_code.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    prpd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_code_byte  (i_code.code_byte),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_valid  (out_valid),
        .i_out_ready  (o_pixel.ready),
        .o_pixel_word (pixel_word),
        .o_run_last   (run_last),
        .o_frame_last (frame_last)
    );

    assign i_code.ready       = in_ready;
    assign o_pixel.valid      = out_valid;
    assign o_pixel.pixel_word = pixel_word;
    assign o_pixel.run_last   = run_last;
    assign o_pixel.frame_last = frame_last;

endmodule

`default_nettype wire

// ===== rtl/prpd_ctrl.sv =====
`default_nettype none

module prpd_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  prpd_pkg::t_stat i_stat,
    output prpd_pkg::t_cmd  o_cmd
);
    import prpd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    // A code byte with an empty run produces nothing.
                    if (!i_stat.run_zero) begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/prpd_dp.sv =====
`default_nettype none

module prpd_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [prpd_pkg::CFG_AW-1:0]  i_cfg_idx,
    input  wire  [prpd_pkg::CFG_DW-1:0]  i_cfg_data,
    input  wire  [prpd_pkg::CODE_W-1:0]  i_code_byte,
    input  prpd_pkg::t_cmd               i_cmd,
    output prpd_pkg::t_stat              o_stat,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [prpd_pkg::PIX_W-1:0]   o_pixel_word,
    output logic                         o_run_last,
    output logic                         o_frame_last
);
    import prpd_pkg::*;

    logic [CFG_DW-1:0] r_pal [PAL_WORDS];
    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [POS_W-1:0]  r_total;
    logic [POS_W-1:0]  r_pos;
    logic [PIX_W-1:0]  r_word;
    logic [RUN_W-1:0]  r_left;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_word;
    logic              r_out_run_last;
    logic              r_out_frame_last;

    logic [IDX_W-1:0]  idx;
    logic [CFG_DW-1:0] pal_word;
    logic [PIX_W-1:0]  colour;
    logic              frame_end;
    logic              last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PAL_WORDS; k++) begin
                r_pal[k] <= '0;
            end
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx) inside
                REG_PAL0, REG_PAL1, REG_PAL2, REG_PAL3: r_pal[i_cfg_idx[1:0]] <= i_cfg_data;
                REG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Image size is registered from the dimension registers; the user must change
    // those only while the block is idle, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= POS_W'(1);
        end else begin
            r_total <= POS_W'(r_width) * POS_W'(r_height);
        end
    end

    assign idx      = i_code_byte[IDX_W-1:0];
    assign pal_word = r_pal[idx[3:2]];
    assign colour   = pal_word[idx[1:0]*PIX_W +: PIX_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= {colour[7:0], colour[15:8]};
        end
    end

    assign frame_end = ({1'b0, r_pos} + 17'd1) >= {1'b0, r_total};
    assign last      = frame_end || (r_left == RUN_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_pos  <= '0;
        end else if (i_cmd.load) begin
            r_left <= i_code_byte[CODE_W-1:IDX_W];
        end else if (i_cmd.emit) begin
            r_left <= r_left - RUN_W'(1);
            r_pos  <= frame_end ? '0 : r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_word       <= r_word;
            r_out_run_last   <= last;
            r_out_frame_last <= frame_end;
        end
    end

    assign o_stat.run_zero = (i_code_byte[CODE_W-1:IDX_W] == '0);
    assign o_stat.last     = last;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_pixel_word = r_out_word;
    assign o_run_last   = r_out_run_last;
    assign o_frame_last = r_out_frame_last;

endmodule

`default_nettype wire

// ===== rtl/prpd_chk.sv =====
`default_nettype none

module prpd_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire [7:0] i_code_byte,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire       i_run_last,
    input wire       i_frame_last
);

    // A stalled output beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat withdrawn while stalled");

    // The pixel that ends a frame also ends its run.
    a_frame_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_last |-> i_run_last)
        else $error("frame_last without run_last");

    // An empty run leaves the input open for the next code byte.
    a_empty_run_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_code_byte[7:4] == 4'd0) |=> i_in_ready)
        else $error("empty run blocked the input");

    // A non-empty run holds the input off while its pixels go out.
    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_code_byte[7:4] != 4'd0) |=> !i_in_ready)
        else $error("input accepted during a run");

endmodule

bind palette_rle_pixel_decoder_top prpd_chk u_prpd_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_code.valid),
    .i_in_ready   (i_code.ready),
    .i_code_byte  (i_code.code_byte),
    .i_out_valid  (o_pixel.valid),
    .i_out_ready  (o_pixel.ready),
    .i_run_last   (o_pixel.run_last),
    .i_frame_last (o_pixel.frame_last)
);

`default_nettype wire

// ===== verif/palette_rle_pixel_decoder_top_test.sv =====
`timescale 1ns / 100ps

module palette_rle_pixel_decoder_top_test;

    import prpd_pkg::*;

    // Indexes past the register list; writes there must change nothing.
    localparam logic [CFG_AW-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_AW-1:0] REG_SPARE_B = 3'd7;

    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned DRAIN_LIMIT   = 200000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned PHASE_ITEMS   = 45;

    typedef struct packed {
        logic [PIX_W-1:0] word;
        logic             run_last;
        logic             frame_last;
    } t_pixel_beat;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_idx = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;

    prpd_code_if  code_if ();
    prpd_pixel_if pixel_if ();

    palette_rle_pixel_decoder_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_code     (code_if),
        .o_pixel    (pixel_if)
    );

    always #2 i_clk = ~i_clk;

    // Shadow of the block's registers and frame position.
    logic [PIX_W-1:0] palette [16];
    logic [DIM_W-1:0] img_width = 1;
    logic [DIM_W-1:0] img_height = 1;
    logic [POS_W-1:0] pixel_pos = '0;

    logic [CODE_W-1:0] code_queue [$];
    t_pixel_beat       pixel_expect_q [$];

    int unsigned codes_taken = 0;
    int unsigned mismatch_count = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    int unsigned hold_left = 0;
    int unsigned hold_token = 0;
    int unsigned hold_seen = 0;
    logic        gap_free = 1'b0;

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Expands one code byte into the pixel beats it should produce.
    function automatic void predict_run(input logic [CODE_W-1:0] code);
        logic [RUN_W-1:0] run_len;
        logic [PIX_W-1:0] colour;
        int unsigned      frame_size;
        t_pixel_beat      beat;
        run_len = code[7:4];
        colour = palette[code[IDX_W-1:0]];
        frame_size = 32'(img_width) * 32'(img_height);
        for (int unsigned k = 0; k < run_len; k++) begin
            beat.word = {colour[7:0], colour[15:8]};
            beat.frame_last = (32'(pixel_pos) + 1) >= frame_size;
            beat.run_last = beat.frame_last || (k + 1 == run_len);
            pixel_expect_q.push_back(beat);
            if (beat.frame_last) begin
                pixel_pos = '0;
                break;
            end
            pixel_pos = pixel_pos + 1'b1;
        end
    endfunction

    // Sender side: offers queued code bytes, with random gaps after each beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            code_if.valid <= 1'b0;
            code_if.code_byte <= '0;
            tx_gap <= 0;
        end else begin
            if (code_if.valid && code_if.ready) begin
                predict_run(code_if.code_byte);
                codes_taken++;
            end
            if (code_if.valid && !code_if.ready) begin
                // Holding the current beat until it is taken.
            end else if (tx_gap != 0) begin
                tx_gap <= tx_gap - 1;
                code_if.valid <= 1'b0;
            end else if (code_queue.size() != 0) begin
                code_if.valid <= 1'b1;
                code_if.code_byte <= code_queue.pop_front();
                tx_gap <= gap_free ? 0 : pick_gap();
            end else begin
                code_if.valid <= 1'b0;
            end
        end
    end

    // Receiver side: checks every pixel beat and throttles ready.
    always @(posedge i_clk) begin : rx_side
        t_pixel_beat want;
        int unsigned gap;
        if (!i_rst_n) begin
            pixel_if.ready <= 1'b0;
            rx_gap <= 0;
            hold_left <= 0;
        end else begin
            if (pixel_if.valid && pixel_if.ready) begin
                if (pixel_expect_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: pixel beat: expected none, got %h/%b/%b",
                             $time, pixel_if.pixel_word, pixel_if.run_last,
                             pixel_if.frame_last);
                end else begin
                    want = pixel_expect_q.pop_front();
                    if (pixel_if.pixel_word !== want.word ||
                        pixel_if.run_last !== want.run_last ||
                        pixel_if.frame_last !== want.frame_last) begin
                        mismatch_count++;
                        $display("%0t: pixel beat: expected %h/%b/%b, got %h/%b/%b",
                                 $time, want.word, want.run_last, want.frame_last,
                                 pixel_if.pixel_word, pixel_if.run_last,
                                 pixel_if.frame_last);
                    end
                end
            end
            if (hold_token != hold_seen) begin
                hold_seen <= hold_token;
                hold_left <= HOLD_CYCLES;
                pixel_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                pixel_if.ready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap <= rx_gap - 1;
                pixel_if.ready <= 1'b0;
            end else if (!pixel_if.ready) begin
                pixel_if.ready <= 1'b1;
            end else if (pixel_if.valid) begin
                gap = gap_free ? 0 : pick_gap();
                if (gap != 0) begin
                    rx_gap <= gap - 1;
                    pixel_if.ready <= 1'b0;
                end
            end
        end
    end

    // Called at a clock edge; the write lands on the next edge.
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_PAL0, REG_PAL1, REG_PAL2, REG_PAL3: begin
                for (int e = 0; e < 4; e++)
                    palette[{idx[1:0], 2'(e)}] = data[16*e +: 16];
            end
            REG_WIDTH:  img_width = data[DIM_W-1:0];
            REG_HEIGHT: img_height = data[DIM_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic close_config();
        i_cfg_we <= 1'b0;
        repeat (2) @(posedge i_clk);
    endtask

    // Upper bits of the size writes carry noise that the block must ignore.
    task automatic load_settings(input logic [63:0] p0, p1, p2, p3,
                                 input logic [DIM_W-1:0] w, h);
        logic [63:0] noise;
        noise = rand_word();
        write_reg(REG_PAL0, p0);
        write_reg(REG_PAL1, p1);
        write_reg(REG_PAL2, p2);
        write_reg(REG_PAL3, p3);
        write_reg(REG_WIDTH, {noise[63:8], w});
        write_reg(REG_HEIGHT, {noise[55:0], h});
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, rand_word());
        close_config();
    endtask

    task automatic drain_all();
        int unsigned waited;
        waited = 0;
        while ((code_queue.size() != 0 || code_if.valid || pixel_expect_q.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT) begin
            mismatch_count++;
            $display("%0t: pixel beats missing: expected %0d more, got none",
                     $time, pixel_expect_q.size());
            pixel_expect_q.delete();
            code_queue.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [CODE_W-1:0] directed_codes [18];
        logic [DIM_W-1:0]  w_val;
        logic [DIM_W-1:0]  h_val;
        int unsigned       taken_mark;

        directed_codes = '{8'h00, 8'hF0, 8'hFF, 8'h1A, 8'h35, 8'h0C, 8'h71, 8'h22, 8'h93,
                           8'h44, 8'hA6, 8'h57, 8'h18, 8'hB9, 8'h6B, 8'hCD, 8'h2E, 8'hE4};
        foreach (palette[i]) palette[i] = '0;
        code_if.valid = 1'b0;
        code_if.code_byte = '0;
        pixel_if.ready = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset settings: a one-pixel image, so every pixel closes a frame.
        code_queue.push_back(8'h10);
        code_queue.push_back(8'hF5);
        drain_all();

        // A 4 x 3 image; runs cross the frame end, every palette index appears in a code byte.
        load_settings(64'h1234_FFFF_00FF_0000, rand_word(), 64'hFF00_8001_A55A_0F0F,
                      {16'hFFFF, 48'(rand_word())}, 8'd4, 8'd3);
        foreach (directed_codes[i]) code_queue.push_back(directed_codes[i]);
        drain_all();

        // Zero width gives an empty image: each run stops after one pixel.
        write_reg(REG_WIDTH, 64'd0);
        close_config();
        code_queue.push_back(8'h31);
        code_queue.push_back(8'hF2);
        code_queue.push_back(8'h00);
        drain_all();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin w_val = 8'd255; h_val = 8'd255; end
                // Shrinks the image below the current position.
                1: begin w_val = 8'd3; h_val = 8'd2; end
                2: begin
                    w_val = DIM_W'($urandom_range(1, 6));
                    h_val = DIM_W'($urandom_range(1, 6));
                end
                3: begin w_val = 8'd1; h_val = 8'd255; end
                4: begin w_val = 8'd255; h_val = 8'd0; end
                default: begin
                    w_val = DIM_W'($urandom_range(1, 20));
                    h_val = DIM_W'($urandom_range(1, 8));
                end
            endcase
            load_settings(rand_word(), rand_word(), rand_word(), rand_word(), w_val, h_val);
            gap_free <= (phase == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                code_queue.push_back(CODE_W'($urandom_range(0, 255)));
            if (phase == 2) begin
                // Stall the receiver long enough to back the block up into its input.
                taken_mark = codes_taken;
                while (codes_taken < taken_mark + 5) @(posedge i_clk);
                hold_token <= hold_token + 1;
            end
            drain_all();
        end

        if (mismatch_count == 0)
            $display("palette_rle_pixel_decoder_top: match");
        else
            $display("palette_rle_pixel_decoder_top: mismatch");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("%0t: run timed out", $time);
        $display("palette_rle_pixel_decoder_top: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/prpd_pkg.sv
rtl/prpd_ifs.sv
rtl/prpd_ctrl.sv
rtl/prpd_dp.sv
rtl/palette_rle_pixel_decoder_top.sv
rtl/prpd_chk.sv
verif/palette_rle_pixel_decoder_top_test.sv
